FILE: hdl/lpwl_pkg.sv
// shared types and constants for the length-prefixed word loader
package lpwl_pkg;

    localparam int POLL_WIDTH    = 16;
    localparam int BYTE_WIDTH    = 8;
    localparam int WORD_WIDTH    = 32;
    localparam int ADDR_WIDTH    = 30;
    localparam int LED_WIDTH     = 2;
    localparam int HDR_CNT_WIDTH = 2;

    localparam int POLL_VALID_BIT = 7;
    localparam int POLL_BYTE_LSB  = 8;

    localparam logic [LED_WIDTH-1:0] LED_HEADER  = 2'h1;
    localparam logic [LED_WIDTH-1:0] LED_PAYLOAD = 2'h3;
    localparam logic [LED_WIDTH-1:0] LED_DONE    = 2'h0;

    typedef struct packed {
        logic                  write_enable;
        logic [ADDR_WIDTH-1:0] write_address;
        logic [WORD_WIDTH-1:0] write_data;
        logic [LED_WIDTH-1:0]  led_value;
        logic                  session_end;
    } lpwl_result_t;

endpackage

FILE: hdl/length_prefixed_word_loader_unit.sv
// Length-prefixed word loader, top level.
// Input channel: poll_word with poll_valid / poll_stall. Each word is one raw
// read of a serial data register; bit 7 flags a received byte in bits 15:8.
// The first four received bytes give the big-endian payload length, later
// bytes are packed big-endian into 32-bit words.
// Output channel: result_valid / result_stall carrying write_enable,
// write_address, write_data, led_value and session_end, one result per word.
// A word passes through the input register, then the result register.
// Throughput: one word per cycle while result_stall is low, set by the
// combinational update of the loader counters and word shifter between the
// two registers.
// While result_stall is high the result register holds; the input register
// still takes one more word, then poll_stall rises until the result leaves.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// loader to the header phase with all counters and the address at zero.
// After session_end, every further word yields an all-zero result.
module length_prefixed_word_loader_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                poll_valid,
    output logic                                poll_stall,
    input  logic [lpwl_pkg::POLL_WIDTH-1:0]     poll_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                write_enable,
    output logic [lpwl_pkg::ADDR_WIDTH-1:0]     write_address,
    output logic [lpwl_pkg::WORD_WIDTH-1:0]     write_data,
    output logic [lpwl_pkg::LED_WIDTH-1:0]      led_value,
    output logic                                session_end
);
    import lpwl_pkg::*;

    logic                  in_valid_reg;
    logic [POLL_WIDTH-1:0] in_poll_reg;
    logic                  res_valid_reg;
    lpwl_result_t          res_reg;
    lpwl_result_t          core_result;
    logic                  res_open;
    logic                  advance;

    assign res_open   = !res_valid_reg || !result_stall;
    assign advance    = in_valid_reg && res_open;
    assign poll_stall = in_valid_reg && !res_open;

    lpwl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .poll   (in_poll_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!poll_stall)
            begin
                in_valid_reg <= poll_valid;
            end
            if (res_open)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && !poll_stall)
        begin
            in_poll_reg <= poll_word;
        end
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid  = res_valid_reg;
    assign write_enable  = res_reg.write_enable;
    assign write_address = res_reg.write_address;
    assign write_data    = res_reg.write_data;
    assign led_value     = res_reg.led_value;
    assign session_end   = res_reg.session_end;

endmodule

FILE: hdl/lpwl_core.sv
// loader state and the per-word update that produces one result
module lpwl_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [lpwl_pkg::POLL_WIDTH-1:0]    poll,
    output lpwl_pkg::lpwl_result_t             result
);
    import lpwl_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [HDR_CNT_WIDTH-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [WORD_WIDTH-1:0]    length_reg, length_next;
    logic [WORD_WIDTH-1:0]    seen_reg, seen_next;
    logic [WORD_WIDTH-1:0]    asm_reg, asm_next;
    logic [ADDR_WIDTH-1:0]    addr_reg, addr_next;

    logic [BYTE_WIDTH-1:0]    rx_byte;
    logic                     rx_valid;
    logic [WORD_WIDTH-1:0]    shifted_len;
    logic [WORD_WIDTH-1:0]    shifted_asm;
    logic [WORD_WIDTH-1:0]    seen_inc;
    logic [HDR_CNT_WIDTH-1:0] hdr_inc;

    assign rx_byte     = poll[POLL_BYTE_LSB +: BYTE_WIDTH];
    assign rx_valid    = poll[POLL_VALID_BIT];
    assign shifted_len = {length_reg[WORD_WIDTH-BYTE_WIDTH-1:0], rx_byte};
    assign shifted_asm = {asm_reg[WORD_WIDTH-BYTE_WIDTH-1:0], rx_byte};
    assign seen_inc    = seen_reg + WORD_WIDTH'(1);
    assign hdr_inc     = hdr_cnt_reg + HDR_CNT_WIDTH'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        asm_next     = asm_reg;
        addr_next    = addr_reg;
        result       = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (rx_valid)
                begin
                    length_next  = shifted_len;
                    hdr_cnt_next = hdr_inc;
                    // fourth length byte closes the header
                    if (hdr_inc == '0)
                    begin
                        if (shifted_len == '0)
                        begin
                            phase_next         = PH_DONE;
                            result.session_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (rx_valid)
                begin
                    asm_next  = shifted_asm;
                    seen_next = seen_inc;
                    if (seen_inc[1:0] == 2'b00)
                    begin
                        result.write_enable  = 1'b1;
                        result.write_address = addr_reg;
                        result.write_data    = shifted_asm;
                        addr_next            = addr_reg + ADDR_WIDTH'(1);
                        asm_next             = '0;
                    end
                    if (seen_inc >= length_reg)
                    begin
                        phase_next         = PH_DONE;
                        result.session_end = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        case (phase_next)
            PH_HEADER:  result.led_value = LED_HEADER;
            PH_PAYLOAD: result.led_value = LED_PAYLOAD;
            default:    result.led_value = LED_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            asm_reg     <= '0;
            addr_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            asm_reg     <= asm_next;
            addr_reg    <= addr_next;
        end
    end

endmodule

FILE: hdl/lpwl_checker.sv
// port-level checks for the word loader, bound to the top level
module lpwl_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic                                write_enable,
    input  logic [lpwl_pkg::ADDR_WIDTH-1:0]     write_address,
    input  logic [lpwl_pkg::WORD_WIDTH-1:0]     write_data,
    input  logic [lpwl_pkg::LED_WIDTH-1:0]      led_value,
    input  logic                                session_end
);
    import lpwl_pkg::*;

    // end of session always reports the finished status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && session_end |-> led_value == LED_DONE)
        else $error("session_end without finished status");

    // no write means zeroed address and data
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !write_enable |-> write_address == '0 && write_data == '0)
        else $error("address or data set without a write");

    // header phase never writes and never ends
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && led_value == LED_HEADER |-> !write_enable && !session_end)
        else $error("write or end during header");

    // once finished, the loader stays finished
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && led_value == LED_DONE
        |=> !result_valid || (led_value == LED_DONE && !session_end && !write_enable))
        else $error("activity after the session ended");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall
        |=> result_valid && $stable(write_data) && $stable(write_address)
            && $stable(led_value) && $stable(session_end) && $stable(write_enable))
        else $error("stalled result changed");

endmodule

bind length_prefixed_word_loader_unit lpwl_checker u_lpwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .write_enable  (write_enable),
    .write_address (write_address),
    .write_data    (write_data),
    .led_value     (led_value),
    .session_end   (session_end)
);
